### hw/rtl/iida_pkg.sv
// Shared types and constants for the interval id allocator.
package iida_pkg;

    // Identifier width and the largest identifier that can be handed out.
    localparam int ID_W = 16;
    localparam logic [ID_W-1:0] MAX_ID = 16'hFFFE;
    localparam int MAX_REGIONS_DEF = 16;
    localparam int STAT_W = 3;
    localparam int OP_W = 2;

    // Request operation codes.
    localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
    localparam logic [OP_W-1:0] OP_RESERVE = 2'd1;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;

    // Result status codes.
    localparam logic [STAT_W-1:0] STAT_OK           = 3'd0;
    localparam logic [STAT_W-1:0] STAT_EXHAUSTED    = 3'd1;
    localparam logic [STAT_W-1:0] STAT_NOT_FREE     = 3'd2;
    localparam logic [STAT_W-1:0] STAT_ALREADY_FREE = 3'd3;
    localparam logic [STAT_W-1:0] STAT_TABLE_FULL   = 3'd4;
    localparam logic [STAT_W-1:0] STAT_INVALID      = 3'd5;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_APPLY
    } t_state;

    // Update applied to the row of cells.
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_ALLOC,
        CMD_ALLOC_REM,
        CMD_RES_HEAD,
        CMD_RES_REM,
        CMD_RES_TAIL,
        CMD_RES_SPLIT,
        CMD_REL_BOTH,
        CMD_REL_LOW,
        CMD_REL_HIGH,
        CMD_REL_INS
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind       kind;
        logic [ID_W-1:0] id;
    } t_cell_cmd;

    // What a cell shows its neighbors.
    typedef struct packed {
        logic [ID_W-1:0] start;
        logic [ID_W-1:0] len;
        logic            valid;
        logic            hit;
        logic            lt;
        logic            pass;
    } t_cell_link;

    // Compare results of one cell against the request id.
    typedef struct packed {
        logic hit;
        logic lt;
        logic head;
        logic head_rem;
        logic tail;
        logic low;
        logic high;
        logic one;
    } t_cell_flags;

    // Row-wide summary handed to the controller.
    typedef struct packed {
        logic            hit_any;
        logic            head_any;
        logic            head_rem_any;
        logic            tail_any;
        logic            low_any;
        logic            high_any;
        logic            full;
        logic            valid0;
        logic            one0;
        logic [ID_W-1:0] start0;
    } t_row_sum;

    localparam t_cell_link LINK_LEFT_EDGE = '{start: '0, len: '0, valid: 1'b0,
                                             hit: 1'b0, lt: 1'b1, pass: 1'b0};
    localparam t_cell_link LINK_RIGHT_EDGE = '{start: '0, len: '0, valid: 1'b0,
                                              hit: 1'b0, lt: 1'b0, pass: 1'b0};

endpackage

### hw/rtl/iida_cell.sv
// One free-region cell: holds a start and length and shifts with its neighbors.
module iida_cell #(
    parameter bit IS_FIRST = 1'b0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  iida_pkg::t_cell_cmd  i_cmd,
    input  iida_pkg::t_cell_link i_left,
    input  iida_pkg::t_cell_link i_right,
    output iida_pkg::t_cell_link o_link,
    output iida_pkg::t_cell_flags o_flags
);
    import iida_pkg::*;

    logic [ID_W-1:0] r_start, n_start;
    logic [ID_W-1:0] r_len, n_len;
    logic            r_valid, n_valid;
    t_cell_flags     r_f, n_f;
    logic [ID_W-1:0] w_last;
    logic [ID_W:0]   w_end;
    logic [ID_W:0]   w_id_p1;

    // Compare the stored region against the request id.
    always_comb begin
        w_last  = r_start + r_len - 1'b1;
        w_end   = {1'b0, r_start} + {1'b0, r_len};
        w_id_p1 = {1'b0, i_cmd.id} + 1'b1;
        n_f.hit      = r_valid && (r_start <= i_cmd.id) && (i_cmd.id <= w_last);
        n_f.lt       = r_valid && (r_start < i_cmd.id);
        n_f.head     = n_f.hit && (r_start == i_cmd.id);
        n_f.tail     = n_f.hit && (w_last == i_cmd.id);
        n_f.head_rem = n_f.head && n_f.tail;
        n_f.low      = r_valid && (w_end == {1'b0, i_cmd.id});
        n_f.high     = r_valid && ({1'b0, r_start} == w_id_p1);
        n_f.one      = r_len == {{(ID_W-1){1'b0}}, 1'b1};
    end

    // Next contents according to the broadcast update.
    always_comb begin
        n_start = r_start;
        n_len   = r_len;
        n_valid = r_valid;
        unique case (i_cmd.kind)
            CMD_NONE: begin
            end
            CMD_ALLOC: begin
                if (IS_FIRST) begin
                    n_start = r_start + 1'b1;
                    n_len   = r_len - 1'b1;
                end
            end
            CMD_ALLOC_REM: begin
                n_start = i_right.start;
                n_len   = i_right.len;
                n_valid = i_right.valid;
            end
            CMD_RES_HEAD: begin
                if (r_f.hit) begin
                    n_start = r_start + 1'b1;
                    n_len   = r_len - 1'b1;
                end
            end
            CMD_RES_REM: begin
                if (i_left.pass || r_f.hit) begin
                    n_start = i_right.start;
                    n_len   = i_right.len;
                    n_valid = i_right.valid;
                end
            end
            CMD_RES_TAIL: begin
                if (r_f.hit) begin
                    n_len = r_len - 1'b1;
                end
            end
            CMD_RES_SPLIT: begin
                if (r_f.hit) begin
                    n_len = i_cmd.id - r_start;
                end else if (i_left.hit) begin
                    n_start = i_cmd.id + 1'b1;
                    n_len   = i_left.start + i_left.len - i_cmd.id - 1'b1;
                    n_valid = 1'b1;
                end else if (i_left.pass) begin
                    n_start = i_left.start;
                    n_len   = i_left.len;
                    n_valid = i_left.valid;
                end
            end
            CMD_REL_BOTH: begin
                if (r_f.low) begin
                    n_len = r_len + 1'b1 + i_right.len;
                end else if (!r_f.lt) begin
                    n_start = i_right.start;
                    n_len   = i_right.len;
                    n_valid = i_right.valid;
                end
            end
            CMD_REL_LOW: begin
                if (r_f.low) begin
                    n_len = r_len + 1'b1;
                end
            end
            CMD_REL_HIGH: begin
                if (r_f.high) begin
                    n_start = r_start - 1'b1;
                    n_len   = r_len + 1'b1;
                end
            end
            CMD_REL_INS: begin
                if (!r_f.lt && i_left.lt) begin
                    n_start = i_cmd.id;
                    n_len   = {{(ID_W-1){1'b0}}, 1'b1};
                    n_valid = 1'b1;
                end else if (!i_left.lt) begin
                    n_start = i_left.start;
                    n_len   = i_left.len;
                    n_valid = i_left.valid;
                end
            end
            default: begin
            end
        endcase
    end

    // Region and flag registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= IS_FIRST;
            r_start <= IS_FIRST ? {{(ID_W-1){1'b0}}, 1'b1} : '0;
            r_len   <= IS_FIRST ? MAX_ID : '0;
            r_f     <= '0;
        end else begin
            r_valid <= n_valid;
            r_start <= n_start;
            r_len   <= n_len;
            r_f     <= n_f;
        end
    end

    assign o_link.start = r_start;
    assign o_link.len   = r_len;
    assign o_link.valid = r_valid;
    assign o_link.hit   = r_f.hit;
    assign o_link.lt    = r_f.lt;
    assign o_link.pass  = i_left.pass || r_f.hit;
    assign o_flags      = r_f;

endmodule

### hw/rtl/iida_ctrl.sv
// Request sequencer: takes a command, decides the row update and the result.
module iida_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    input  logic [iida_pkg::OP_W-1:0]      i_op,
    input  logic [iida_pkg::ID_W-1:0]      i_req_id,
    input  iida_pkg::t_row_sum             i_sum,
    output logic                           busy,
    output logic                           o_done,
    output logic [iida_pkg::ID_W-1:0]      o_out_id,
    output logic [iida_pkg::STAT_W-1:0]    o_status,
    output iida_pkg::t_cell_cmd            o_cmd
);
    import iida_pkg::*;

    t_state          r_state, n_state;
    logic [OP_W-1:0] r_op;
    logic [ID_W-1:0] r_id;
    logic            w_accept;
    logic            w_bad;
    t_cmd_kind       w_kind;
    logic [STAT_W-1:0] w_status;

    assign w_accept = start && !busy;

    // State register and captured request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op <= i_op;
            r_id <= i_req_id;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (start) n_state = S_EXEC;
            S_EXEC:  n_state = S_APPLY;
            S_APPLY: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Decide the update and the status from the registered compare results.
    always_comb begin
        w_bad    = (r_id == '0) || (r_id > MAX_ID);
        w_kind   = CMD_NONE;
        w_status = STAT_OK;
        if (r_op == OP_ALLOC) begin
            if (!i_sum.valid0) begin
                w_status = STAT_EXHAUSTED;
            end else begin
                w_kind = i_sum.one0 ? CMD_ALLOC_REM : CMD_ALLOC;
            end
        end else if (r_op != OP_RESERVE && r_op != OP_RELEASE || w_bad) begin
            w_status = STAT_INVALID;
        end else if (r_op == OP_RESERVE) begin
            priority if (!i_sum.hit_any) begin
                w_status = STAT_NOT_FREE;
            end else if (i_sum.head_rem_any) begin
                w_kind = CMD_RES_REM;
            end else if (i_sum.head_any) begin
                w_kind = CMD_RES_HEAD;
            end else if (i_sum.tail_any) begin
                w_kind = CMD_RES_TAIL;
            end else if (i_sum.full) begin
                w_status = STAT_TABLE_FULL;
            end else begin
                w_kind = CMD_RES_SPLIT;
            end
        end else begin
            priority if (i_sum.hit_any) begin
                w_status = STAT_ALREADY_FREE;
            end else if (i_sum.low_any && i_sum.high_any) begin
                w_kind = CMD_REL_BOTH;
            end else if (i_sum.low_any) begin
                w_kind = CMD_REL_LOW;
            end else if (i_sum.high_any) begin
                w_kind = CMD_REL_HIGH;
            end else if (i_sum.full) begin
                w_status = STAT_TABLE_FULL;
            end else begin
                w_kind = CMD_REL_INS;
            end
        end
    end

    // Outputs: the update fires and the result shows in the apply cycle.
    assign busy       = (r_state != S_IDLE);
    assign o_done     = (r_state == S_APPLY);
    assign o_cmd.kind = o_done ? w_kind : CMD_NONE;
    assign o_cmd.id   = r_id;
    assign o_status   = o_done ? w_status : STAT_OK;
    assign o_out_id   = (!o_done || w_status != STAT_OK) ? '0 :
                        (r_op == OP_ALLOC) ? i_sum.start0 : r_id;

`ifndef NO_ASSERTIONS
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_EXEC))
        else $error("accepted request did not enter execute");
    a_exec_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |=> o_done)
        else $error("result strobe missing after execute");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != STAT_OK) |-> (o_out_id == '0))
        else $error("error result carries a nonzero id");
    a_no_update_on_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != STAT_OK) |-> (o_cmd.kind == CMD_NONE))
        else $error("table updated on an error");
`endif

endmodule

### hw/rtl/interval_id_allocator_unit.sv
// Top level of the interval id allocator: controller plus a row of region cells.
//
//  channel   | signals                              | handshake
//  ----------+--------------------------------------+-----------------------------
//  request   | i_op, i_req_id                       | start high while busy low
//  result    | o_out_id, o_status                   | o_done strobe, one cycle
//
// Every request passes through two states after its accepting edge: execute, in which
// all cells compare the id in parallel, and apply, in which the row shifts or edits its
// entries and the result is shown. busy stays high through both, so the next request is
// accepted only once the controller is back in idle; requests never overlap.
// Synchronous active-low reset leaves one free region covering ids 1 to MAX_ID.
// The result cannot be stalled; it is transferred in its single strobe cycle.
module interval_id_allocator_unit #(
    parameter int MAX_REGIONS = iida_pkg::MAX_REGIONS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    input  logic [iida_pkg::OP_W-1:0]      i_op,
    input  logic [iida_pkg::ID_W-1:0]      i_req_id,
    output logic                           busy,
    output logic                           o_done,
    output logic [iida_pkg::ID_W-1:0]      o_out_id,
    output logic [iida_pkg::STAT_W-1:0]    o_status
);
    import iida_pkg::*;

    t_cell_cmd   w_cmd;
    t_cell_link  w_link  [MAX_REGIONS];
    t_cell_flags w_flags [MAX_REGIONS];
    t_row_sum    w_sum;

    // Row of region cells.
    for (genvar g = 0; g < MAX_REGIONS; g++) begin : g_cell
        t_cell_link w_left, w_right;
        if (g == 0) begin : g_l0
            assign w_left = LINK_LEFT_EDGE;
        end else begin : g_ln
            assign w_left = w_link[g-1];
        end
        if (g == MAX_REGIONS - 1) begin : g_rl
            assign w_right = LINK_RIGHT_EDGE;
        end else begin : g_rn
            assign w_right = w_link[g+1];
        end
        iida_cell #(
            .IS_FIRST(g == 0)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (w_cmd),
            .i_left  (w_left),
            .i_right (w_right),
            .o_link  (w_link[g]),
            .o_flags (w_flags[g])
        );
    end

    // Gather the row-wide summary for the controller.
    always_comb begin
        w_sum = '0;
        for (int i = 0; i < MAX_REGIONS; i++) begin
            w_sum.hit_any      = w_sum.hit_any      | w_flags[i].hit;
            w_sum.head_any     = w_sum.head_any     | w_flags[i].head;
            w_sum.head_rem_any = w_sum.head_rem_any | w_flags[i].head_rem;
            w_sum.tail_any     = w_sum.tail_any     | w_flags[i].tail;
            w_sum.low_any      = w_sum.low_any      | w_flags[i].low;
            w_sum.high_any     = w_sum.high_any     | w_flags[i].high;
        end
        w_sum.full   = w_link[MAX_REGIONS-1].valid;
        w_sum.valid0 = w_link[0].valid;
        w_sum.one0   = w_flags[0].one;
        w_sum.start0 = w_link[0].start;
    end

    iida_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_op     (i_op),
        .i_req_id (i_req_id),
        .i_sum    (w_sum),
        .busy     (busy),
        .o_done   (o_done),
        .o_out_id (o_out_id),
        .o_status (o_status),
        .o_cmd    (w_cmd)
    );

endmodule
